// ===== rtl/core/dgsp_pkg.sv =====
// Shared constants, codes and types for the dense graph shortest path core.
// No dependencies; every other file refers to this package by scoped names.

package dgsp_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int WEIGHT_BITS_DEF  = 16;

   // fixed field widths of the request and response channels
   localparam int ROW_W    = 6;
   localparam int VCOUNT_W = 7;
   localparam int SRC_W    = 6;
   localparam int VERTEX_W = 6;
   localparam int DIST_W   = 22;
   localparam int PRED_W   = 7;

   localparam logic [DIST_W-1:0] DIST_MAX  = 22'h3FFFFF;
   localparam logic [PRED_W-1:0] PRED_NONE = 7'd64;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE       = 1'b1;
   localparam logic [VCOUNT_W-1:0]  VCOUNT_RESET     = 7'd64;

   // request action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_RUN   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT,
      ST_INIT_SRC,
      ST_SCAN,
      ST_SCAN_END,
      ST_RELAX,
      ST_OUT_RD,
      ST_OUT_LOAD,
      ST_OUT_SEND
   } state_type;

endpackage

// ===== rtl/core/dgsp_if.sv =====
// Request and response channel interfaces (valid/ready) of the shortest path core.
// Depends on dgsp_pkg for field widths.

interface dgsp_req_if #(
   parameter int WEIGHT_BITS = dgsp_pkg::WEIGHT_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [dgsp_pkg::ROW_W-1:0]   row;
   logic [dgsp_pkg::ROW_W-1:0]   col;
   logic [WEIGHT_BITS-1:0]       weight;

   modport source (output valid, action, row, col, weight, input ready);
   modport sink   (input valid, action, row, col, weight, output ready);
endinterface

interface dgsp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dgsp_pkg::VERTEX_W-1:0]   vertex;
   logic [dgsp_pkg::DIST_W-1:0]     distance;
   logic [dgsp_pkg::PRED_W-1:0]     predecessor;
   logic                            reachable;
   logic                            last;

   modport source (output valid, vertex, distance, predecessor, reachable, last,
                   input ready);
   modport sink   (input valid, vertex, distance, predecessor, reachable, last,
                   output ready);
endinterface

// ===== rtl/core/dgsp_edge_mem.sv =====
// Adjacency matrix store: one write port, one registered read port, and a
// clearing pass after reset that fills every entry with the no-edge code.

module dgsp_edge_mem #(
   parameter int MAX_VERTICES = dgsp_pkg::MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = dgsp_pkg::WEIGHT_BITS_DEF,
   localparam int VW = $clog2(MAX_VERTICES),
   localparam int AW = 2 * VW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [WEIGHT_BITS-1:0] wr_data,
   input  logic [AW-1:0]          rd_addr,
   output logic [WEIGHT_BITS-1:0] rd_data,
   output logic                   clr_busy
);

   localparam int DEPTH = 1 << AW;
   localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};

   logic [WEIGHT_BITS-1:0] mem [0:DEPTH-1];

   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic                   clr_busy_ff, clr_busy_in;
   logic [WEIGHT_BITS-1:0] rd_data_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [WEIGHT_BITS-1:0] mem_wdata;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == {AW{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // the sweep owns the write port until it is done
   always_comb begin
      mem_we    = clr_busy_ff | wr_en;
      mem_waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
      mem_wdata = clr_busy_ff ? NO_EDGE : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// ===== rtl/core/dense_graph_shortest_path_core.sv =====
// Top level of the dense graph shortest path core: sequencer, per-vertex
// scratch memory and response register. Depends on dgsp_pkg, dgsp_if, dgsp_edge_mem.
//
//   port       dir    handshake       carries
//   req_bus    in     valid/ready     action, row, col, weight
//   rsp_bus    out    valid/ready     vertex, distance, predecessor, reachable, last
//   csr_*      in     write enable    vertex_count (index 0), source_vertex (index 1)
//
// A weight write is taken while idle. A run with n vertices has a setup pass
// over all n entries, then per settled vertex a minimum search and a
// relaxation pass, all through one scratch memory read port and one adder,
// then the results, one per vertex, each held while rsp_bus.ready is low.
// After reset a sweep over all 2^(2*clog2(MAX_VERTICES)) entries (4096 by default) fills the
// matrix with the no-edge code; req_bus.ready stays low until it ends.
// req_bus.ready is low for the whole run and while results are delivered.

module dense_graph_shortest_path_core #(
   parameter int MAX_VERTICES = dgsp_pkg::MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = dgsp_pkg::WEIGHT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [dgsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dgsp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   dgsp_req_if.sink                          req_bus,
   dgsp_rsp_if.source                        rsp_bus
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int AW = 2 * VW;
   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int DW = WEIGHT_BITS + VW;
   localparam int CW = (DW > dgsp_pkg::DIST_W) ? DW : dgsp_pkg::DIST_W;
   localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};
   localparam int SCR_DEPTH = 1 << VW;

   typedef struct packed {
      logic          reached;
      logic          settled;
      logic          pnone;
      logic [VW-1:0] parent;
      logic [DW-1:0] path_dist;
   } scr_entry_type;

   // configuration
   logic [dgsp_pkg::VCOUNT_W-1:0] vcount_ff;
   logic [dgsp_pkg::SRC_W-1:0]    src_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= dgsp_pkg::VCOUNT_RESET;
         src_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            dgsp_pkg::CSR_VERTEX_COUNT: vcount_ff <= csr_wdata[dgsp_pkg::VCOUNT_W-1:0];
            dgsp_pkg::CSR_SOURCE:       src_ff    <= csr_wdata[dgsp_pkg::SRC_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer state and datapath registers
   dgsp_pkg::state_type state_ff, state_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [NW-1:0]  idx_ff, idx_in;
   logic [NW-1:0]  round_ff, round_in;
   logic           pipe_vld_ff, pipe_vld_in;
   logic [VW-1:0]  pipe_idx_ff, pipe_idx_in;
   logic           found_ff, found_in;
   logic [VW-1:0]  k_ff, k_in;
   logic [DW-1:0]  best_ff, best_in;

   logic                           rsp_vld_ff, rsp_vld_in;
   logic [dgsp_pkg::VERTEX_W-1:0]  rsp_vertex_ff, rsp_vertex_in;
   logic [dgsp_pkg::DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic [dgsp_pkg::PRED_W-1:0]    rsp_pred_ff, rsp_pred_in;
   logic                           rsp_reach_ff, rsp_reach_in;
   logic                           rsp_last_ff, rsp_last_in;

   // scratch memory
   scr_entry_type scr_mem [0:SCR_DEPTH-1];
   scr_entry_type scr_rd_ff;
   scr_entry_type scr_wdata;
   logic          scr_we;
   logic [VW-1:0] scr_waddr;
   logic [VW-1:0] scr_raddr;

   // edge matrix
   logic                   edge_we;
   logic [AW-1:0]          edge_waddr;
   logic [AW-1:0]          edge_raddr;
   logic [WEIGHT_BITS-1:0] edge_rdata;
   logic                   clr_busy;

   dgsp_edge_mem #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_edge_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (edge_we),
      .wr_addr  (edge_waddr),
      .wr_data  (WEIGHT_BITS'(req_bus.weight)),
      .rd_addr  (edge_raddr),
      .rd_data  (edge_rdata),
      .clr_busy (clr_busy)
   );

   // shared decode
   logic                          req_fire;
   logic [dgsp_pkg::VCOUNT_W-1:0] n_clamp;
   logic                          src_ok;
   logic                          scan_done;
   logic                          out_last;
   logic                          more_rounds;
   logic [DW-1:0]                 cand;
   logic [CW-1:0]                 dist_ext;

   always_comb begin
      req_fire = req_bus.valid && (state_ff == dgsp_pkg::ST_IDLE);
      if (vcount_ff == '0) begin
         n_clamp = dgsp_pkg::VCOUNT_W'(1);
      end else if (vcount_ff > dgsp_pkg::VCOUNT_W'(MAX_VERTICES)) begin
         n_clamp = dgsp_pkg::VCOUNT_W'(MAX_VERTICES);
      end else begin
         n_clamp = vcount_ff;
      end
      src_ok      = (8'(src_ff) < 8'(n_ff));
      scan_done   = (idx_ff == n_ff);
      out_last    = ((NW + 1)'(idx_ff) + (NW + 1)'(1)) == (NW + 1)'(n_ff);
      more_rounds = ((NW + 1)'(round_ff) + (NW + 1)'(1)) < (NW + 1)'(n_ff);
      cand        = best_ff + DW'(edge_rdata);
      dist_ext    = CW'(scr_rd_ff.path_dist);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dgsp_pkg::ST_CLEAR: begin
            if (!clr_busy) state_in = dgsp_pkg::ST_IDLE;
         end
         dgsp_pkg::ST_IDLE: begin
            if (req_fire && req_bus.action == dgsp_pkg::ACT_RUN) begin
               state_in = dgsp_pkg::ST_INIT;
            end
         end
         dgsp_pkg::ST_INIT: begin
            if (scan_done) state_in = dgsp_pkg::ST_INIT_SRC;
         end
         dgsp_pkg::ST_INIT_SRC: begin
            // a single vertex has no rounds to run
            if (!src_ok || n_ff < NW'(2)) state_in = dgsp_pkg::ST_OUT_RD;
            else                          state_in = dgsp_pkg::ST_SCAN;
         end
         dgsp_pkg::ST_SCAN: begin
            if (scan_done) state_in = dgsp_pkg::ST_SCAN_END;
         end
         dgsp_pkg::ST_SCAN_END: begin
            state_in = found_ff ? dgsp_pkg::ST_RELAX : dgsp_pkg::ST_OUT_RD;
         end
         dgsp_pkg::ST_RELAX: begin
            if (scan_done) begin
               state_in = more_rounds ? dgsp_pkg::ST_SCAN : dgsp_pkg::ST_OUT_RD;
            end
         end
         dgsp_pkg::ST_OUT_RD:   state_in = dgsp_pkg::ST_OUT_LOAD;
         dgsp_pkg::ST_OUT_LOAD: state_in = dgsp_pkg::ST_OUT_SEND;
         dgsp_pkg::ST_OUT_SEND: begin
            if (rsp_bus.ready) begin
               state_in = out_last ? dgsp_pkg::ST_IDLE : dgsp_pkg::ST_OUT_RD;
            end
         end
         default: state_in = dgsp_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      n_in          = n_ff;
      idx_in        = idx_ff;
      round_in      = round_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = idx_ff[VW-1:0];
      found_in      = found_ff;
      k_in          = k_ff;
      best_in       = best_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_pred_in   = rsp_pred_ff;
      rsp_reach_in  = rsp_reach_ff;
      rsp_last_in   = rsp_last_ff;

      scr_we    = 1'b0;
      scr_waddr = pipe_idx_ff;
      scr_wdata = scr_rd_ff;
      scr_raddr = idx_ff[VW-1:0];

      edge_we    = 1'b0;
      edge_waddr = {req_bus.row[VW-1:0], req_bus.col[VW-1:0]};
      edge_raddr = {k_ff, idx_ff[VW-1:0]};

      unique case (state_ff)
         dgsp_pkg::ST_CLEAR: ;
         dgsp_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.action == dgsp_pkg::ACT_WRITE) begin
                  edge_we = (7'(req_bus.row) < 7'(MAX_VERTICES)) &&
                            (7'(req_bus.col) < 7'(MAX_VERTICES));
               end else begin
                  n_in   = NW'(n_clamp);
                  idx_in = '0;
               end
            end
         end
         dgsp_pkg::ST_INIT: begin
            edge_raddr = {src_ff[VW-1:0], idx_ff[VW-1:0]};
            if (!scan_done) begin
               pipe_vld_in = 1'b1;
               idx_in      = idx_ff + NW'(1);
            end
            if (pipe_vld_ff) begin
               scr_we            = 1'b1;
               scr_wdata.settled = 1'b0;
               scr_wdata.pnone   = 1'b1;
               scr_wdata.parent  = '0;
               if (src_ok && edge_rdata != NO_EDGE) begin
                  scr_wdata.reached   = 1'b1;
                  scr_wdata.path_dist = DW'(edge_rdata);
               end else begin
                  scr_wdata.reached   = 1'b0;
                  scr_wdata.path_dist = '0;
               end
            end
         end
         dgsp_pkg::ST_INIT_SRC: begin
            scr_we    = src_ok;
            scr_waddr = src_ff[VW-1:0];
            scr_wdata = '{reached: 1'b1, settled: 1'b1, pnone: 1'b1,
                          parent: '0, path_dist: '0};
            round_in  = NW'(1);
            idx_in    = '0;
            found_in  = 1'b0;
         end
         dgsp_pkg::ST_SCAN: begin
            if (!scan_done) begin
               pipe_vld_in = 1'b1;
               idx_in      = idx_ff + NW'(1);
            end
            // strict compare keeps the lowest index among equal distances
            if (pipe_vld_ff && !scr_rd_ff.settled && scr_rd_ff.reached &&
                (!found_ff || scr_rd_ff.path_dist < best_ff)) begin
               found_in = 1'b1;
               k_in     = pipe_idx_ff;
               best_in  = scr_rd_ff.path_dist;
            end
         end
         dgsp_pkg::ST_SCAN_END: begin
            idx_in = '0;
         end
         dgsp_pkg::ST_RELAX: begin
            if (!scan_done) begin
               pipe_vld_in = 1'b1;
               idx_in      = idx_ff + NW'(1);
            end else begin
               round_in = round_ff + NW'(1);
               idx_in   = '0;
               found_in = 1'b0;
            end
            if (pipe_vld_ff) begin
               if (pipe_idx_ff == k_ff) begin
                  // the vertex picked this round is settled here
                  scr_we            = 1'b1;
                  scr_wdata.settled = 1'b1;
               end else if (!scr_rd_ff.settled && edge_rdata != NO_EDGE &&
                            (!scr_rd_ff.reached || cand < scr_rd_ff.path_dist)) begin
                  scr_we    = 1'b1;
                  scr_wdata = '{reached: 1'b1, settled: 1'b0, pnone: 1'b0,
                                parent: k_ff, path_dist: cand};
               end
            end
            if (scan_done && !more_rounds) begin
               idx_in = '0;
            end
         end
         dgsp_pkg::ST_OUT_RD: ;
         dgsp_pkg::ST_OUT_LOAD: begin
            rsp_vld_in    = 1'b1;
            rsp_vertex_in = dgsp_pkg::VERTEX_W'(idx_ff);
            rsp_reach_in  = scr_rd_ff.reached;
            rsp_last_in   = out_last;
            if (!scr_rd_ff.reached) begin
               rsp_dist_in = '0;
            end else if (dist_ext > CW'(dgsp_pkg::DIST_MAX)) begin
               rsp_dist_in = dgsp_pkg::DIST_MAX;
            end else begin
               rsp_dist_in = dist_ext[dgsp_pkg::DIST_W-1:0];
            end
            if (scr_rd_ff.reached && !scr_rd_ff.pnone) begin
               rsp_pred_in = dgsp_pkg::PRED_W'(scr_rd_ff.parent);
            end else begin
               rsp_pred_in = dgsp_pkg::PRED_NONE;
            end
         end
         dgsp_pkg::ST_OUT_SEND: begin
            if (rsp_bus.ready) begin
               rsp_vld_in = 1'b0;
               idx_in     = idx_ff + NW'(1);
            end
         end
         default: ;
      endcase

      // scan index restarts on entry to the result phase from ST_INIT_SRC or ST_SCAN_END
      if (state_in == dgsp_pkg::ST_OUT_RD &&
          (state_ff == dgsp_pkg::ST_INIT_SRC || state_ff == dgsp_pkg::ST_SCAN_END)) begin
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dgsp_pkg::ST_CLEAR;
         pipe_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         found_ff    <= 1'b0;
         n_ff        <= '0;
         idx_ff      <= '0;
         round_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= pipe_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         found_ff    <= found_in;
         n_ff        <= n_in;
         idx_ff      <= idx_in;
         round_ff    <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_idx_ff   <= pipe_idx_in;
      k_ff          <= k_in;
      best_ff       <= best_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_pred_ff   <= rsp_pred_in;
      rsp_reach_ff  <= rsp_reach_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[scr_waddr] <= scr_wdata;
      end
      scr_rd_ff <= scr_mem[scr_raddr];
   end

   assign req_bus.ready       = (state_ff == dgsp_pkg::ST_IDLE);
   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.vertex      = rsp_vertex_ff;
   assign rsp_bus.distance    = rsp_dist_ff;
   assign rsp_bus.predecessor = rsp_pred_ff;
   assign rsp_bus.reachable   = rsp_reach_ff;
   assign rsp_bus.last        = rsp_last_ff;

endmodule
